[hw/rtl/assert_macros.svh]
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dip_pkg.sv]
// Types, codes and helper functions for the decimal integer field parser.
package dip_pkg;

    localparam int ACC_W   = 34;
    localparam int VALUE_W = 33;
    localparam int CNT_W   = 4;

    // number kinds
    localparam logic [1:0] KIND_U32 = 2'd0;
    localparam logic [1:0] KIND_U16 = 2'd1;
    localparam logic [1:0] KIND_U8  = 2'd2;
    localparam logic [1:0] KIND_I16 = 2'd3;

    // result reasons
    localparam logic [1:0] REASON_OK       = 2'd0;
    localparam logic [1:0] REASON_NO_DIGIT = 2'd1;
    localparam logic [1:0] REASON_TOO_LONG = 2'd2;
    localparam logic [1:0] REASON_RANGE    = 2'd3;

    // parser phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_MINUS  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [CNT_W-1:0] DIGIT_LIMIT_U32 = 4'd10;
    localparam logic [CNT_W-1:0] DIGIT_LIMIT_U8  = 4'd3;
    localparam logic [CNT_W-1:0] DIGIT_LIMIT_16  = 4'd5;

    localparam logic [ACC_W-1:0] LIM_U32     = 34'h0_FFFF_FFFF;
    localparam logic [ACC_W-1:0] LIM_U16     = 34'd65535;
    localparam logic [ACC_W-1:0] LIM_U8      = 34'd255;
    localparam logic [ACC_W-1:0] LIM_I16_POS = 34'd32767;
    localparam logic [ACC_W-1:0] LIM_I16_NEG = 34'd32768;

    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
        logic [1:0] kind;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      ok;
        logic [1:0]                reason;
    } out_item_t;

    function automatic logic [CNT_W-1:0] digit_limit(input logic [1:0] k);
        logic [CNT_W-1:0] m;
        unique case (k)
            KIND_U32: m = DIGIT_LIMIT_U32;
            KIND_U8:  m = DIGIT_LIMIT_U8;
            default:  m = DIGIT_LIMIT_16;
        endcase
        return m;
    endfunction

    function automatic logic [ACC_W-1:0] range_limit(input logic [1:0] k, input logic neg);
        logic [ACC_W-1:0] l;
        unique case (k)
            KIND_U32: l = LIM_U32;
            KIND_U16: l = LIM_U16;
            KIND_U8:  l = LIM_U8;
            default:  l = neg ? LIM_I16_NEG : LIM_I16_POS;
        endcase
        return l;
    endfunction

endpackage

[hw/rtl/decimal_integer_field_parser.sv]
// Decimal integer field parser: one ASCII character per request, one result per number.
// Takes one character request in every clock cycle unless a held result stalls; the result for a number is
// registered and shows on the out channel in the cycle after the request that ends
// the number (a non-digit, end of buffer, or a digit past the kind's limit). The
// ending character is not part of the number and starts nothing new. in_ready is
// low only while a held result is stalled by out_ready, so the rate is one request
// per cycle, set by the single register stage holding the parse state and the
// times-ten shift-add accumulator.
`include "assert_macros.svh"

module decimal_integer_field_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dip_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dip_pkg::out_item_t out_data
);
    import dip_pkg::*;

    logic [1:0]       phase_reg, phase_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [1:0]       kind_reg, kind_next;
    logic             out_valid_reg;
    out_item_t        out_data_reg, res;

    logic             accept;
    logic             emit;
    logic             is_digit;
    logic [ACC_W-1:0] digit;
    logic [ACC_W-1:0] acc_x10;
    logic [ACC_W-1:0] lim;
    logic [CNT_W:0]   cnt_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign is_digit = !in_data.at_end && (in_data.ch >= CH_ZERO) && (in_data.ch <= CH_NINE);
    assign digit    = {{(ACC_W-4){1'b0}}, in_data.ch[3:0]};
    assign acc_x10  = (acc_reg << 3) + (acc_reg << 1);
    assign lim      = range_limit(kind_reg, neg_reg);
    assign cnt_inc  = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        kind_next  = kind_reg;
        emit       = 1'b0;
        res.value  = '0;
        res.ok     = 1'b0;
        res.reason = REASON_NO_DIGIT;

        unique case (phase_reg)
            PH_IDLE:
            begin
                kind_next = in_data.kind;
                if (!in_data.at_end && in_data.kind == KIND_I16 && in_data.ch == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_MINUS;
                end
                else if (!is_digit)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    acc_next   = digit;
                    cnt_next   = CNT_W'(1);
                    phase_next = PH_DIGITS;
                end
            end
            PH_MINUS:
            begin
                if (!is_digit)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    acc_next   = digit;
                    cnt_next   = CNT_W'(1);
                    phase_next = PH_DIGITS;
                end
            end
            PH_DIGITS:
            begin
                if (!is_digit)
                begin
                    emit = 1'b1;
                    if (acc_reg > lim)
                    begin
                        res.reason = REASON_RANGE;
                    end
                    else
                    begin
                        res.reason = REASON_OK;
                        res.ok     = 1'b1;
                        res.value  = (kind_reg == KIND_I16 && neg_reg)
                                   ? -$signed(acc_reg[VALUE_W-1:0])
                                   : $signed(acc_reg[VALUE_W-1:0]);
                    end
                end
                else if (cnt_inc > {1'b0, digit_limit(kind_reg)})
                begin
                    emit       = 1'b1;
                    res.reason = REASON_TOO_LONG;
                end
                else
                begin
                    acc_next = acc_x10 + digit;
                    cnt_next = cnt_inc[CNT_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // a finished number always returns the parser to idle
        if (emit)
        begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            cnt_next   = '0;
            neg_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            kind_reg      <= KIND_U32;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                neg_reg   <= neg_next;
                kind_reg  <= kind_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= res;
        end
    end

    `ASSERT_IMPL(a_ok_matches_reason, out_valid, out_data.ok == (out_data.reason == REASON_OK), "ok flag disagrees with reason")
    `ASSERT_IMPL(a_fail_value_zero, out_valid && !out_data.ok, out_data.value == '0, "failed result carries a nonzero value")
    `ASSERT_IMPL(a_digit_count_range, phase_reg == PH_DIGITS, cnt_reg != '0 && cnt_reg <= digit_limit(kind_reg), "digit count outside kind limit")
    `ASSERT_IMPL(a_minus_only_i16, phase_reg == PH_MINUS, neg_reg && kind_reg == KIND_I16 && acc_reg == '0, "minus phase without i16 sign state")
    `ASSERT_NEXT(a_emit_sets_valid, accept && emit, out_valid, "finished number produced no result")

endmodule

[verif/tb.sv]
// Self-checking testbench for the decimal integer field parser: queued char stream in, numbers out.
module tb;
    import dip_pkg::*;

    localparam int N_CHARS   = 1700;
    localparam int CALM_LEFT = 150;
    localparam int MAX_CYC   = 200000;

    typedef struct packed {
        in_item_t item;
        logic     drain;
    } char_req_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    decimal_integer_field_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    char_req_t char_queue[$];
    out_item_t numbers_due[$];
    int        items_queued = 0;
    bit        drain_next = 0;

    // parser shadow state
    logic [1:0]  parse_phase = PH_IDLE;
    logic [33:0] acc = '0;
    logic [3:0]  ndigits = '0;
    logic        minus_seen = 1'b0;
    logic [1:0]  kind_held = KIND_U32;

    int  cycles = 0;
    int  errors = 0;
    int  chars_taken = 0;
    int  numbers_checked = 0;
    int  reason_seen[4] = '{0, 0, 0, 0};
    bit  in_taken = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  long_hold_done = 0;

    function automatic bit calm_phase();
        return char_queue.size() < CALM_LEFT;
    endfunction

    task automatic close_number(input logic signed [32:0] v, input logic [1:0] why);
        out_item_t r;
        r.value  = (why == REASON_OK) ? v : '0;
        r.ok     = (why == REASON_OK);
        r.reason = why;
        numbers_due.push_back(r);
        parse_phase = PH_IDLE;
        acc         = '0;
        ndigits     = '0;
        minus_seen  = 1'b0;
    endtask

    task automatic advance_parser(input in_item_t it);
        logic        digit;
        logic [3:0]  d;
        int          digit_cap;
        logic [33:0] limit;
        logic [33:0] neg_acc;
        digit = !it.at_end && it.ch >= CH_ZERO && it.ch <= CH_NINE;
        d = digit ? 4'(it.ch - CH_ZERO) : 4'd0;
        case (kind_held)
            KIND_U32: digit_cap = 10;
            KIND_U8:  digit_cap = 3;
            default:  digit_cap = 5;
        endcase
        case (parse_phase)
            PH_IDLE: begin
                kind_held = it.kind;
                if (!it.at_end && kind_held == KIND_I16 && it.ch == CH_MINUS) begin
                    minus_seen  = 1'b1;
                    parse_phase = PH_MINUS;
                end
                else if (!digit)
                    close_number('0, REASON_NO_DIGIT);
                else begin
                    acc         = 34'(d);
                    ndigits     = 4'd1;
                    parse_phase = PH_DIGITS;
                end
            end
            PH_MINUS: begin
                if (!digit)
                    close_number('0, REASON_NO_DIGIT);
                else begin
                    acc         = 34'(d);
                    ndigits     = 4'd1;
                    parse_phase = PH_DIGITS;
                end
            end
            default: begin
                if (!digit) begin
                    case (kind_held)
                        KIND_U32: limit = 34'h0_FFFF_FFFF;
                        KIND_U16: limit = 34'd65535;
                        KIND_U8:  limit = 34'd255;
                        default:  limit = minus_seen ? 34'd32768 : 34'd32767;
                    endcase
                    if (acc > limit)
                        close_number('0, REASON_RANGE);
                    else if (kind_held == KIND_I16 && minus_seen) begin
                        neg_acc = -acc;
                        close_number(neg_acc[32:0], REASON_OK);
                    end
                    else
                        close_number(acc[32:0], REASON_OK);
                end
                else if (int'(ndigits) + 1 > digit_cap)
                    close_number('0, REASON_TOO_LONG);
                else begin
                    acc     = acc * 34'd10 + 34'(d);
                    ndigits = ndigits + 4'd1;
                end
            end
        endcase
    endtask

    task automatic push_char(input logic [7:0] c, input logic e, input logic [1:0] k);
        char_req_t r;
        r.item.ch     = c;
        r.item.at_end = e;
        r.item.kind   = k;
        r.drain       = drain_next;
        drain_next    = 0;
        char_queue.push_back(r);
        items_queued++;
    endtask

    task automatic push_text(input string s, input logic [1:0] k);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 1'b0, k);
    endtask

    function automatic logic [7:0] any_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CH_ZERO && c <= CH_NINE);
        return c;
    endfunction

    // one well-formed number with random content; kind only matters on the first char
    task automatic queue_number();
        logic [1:0]  k;
        logic        neg;
        int          maxd;
        longint      mag;
        longint      lim;
        logic [7:0]  digs[$];
        bit          first;
        k    = 2'($urandom_range(0, 3));
        neg  = (k == KIND_I16) && ($urandom_range(0, 2) != 0);
        maxd = (k == KIND_U32) ? 10 : (k == KIND_U8) ? 3 : 5;
        if ($urandom_range(0, 3) == 0) begin
            // straddle the range limit
            case (k)
                KIND_U32: lim = 64'hFFFF_FFFF;
                KIND_U16: lim = 65535;
                KIND_U8:  lim = 255;
                default:  lim = neg ? 32768 : 32767;
            endcase
            mag = lim - 2 + longint'($urandom_range(0, 4));
            while (mag > 0) begin
                digs.push_front(8'(CH_ZERO + 8'(mag % 10)));
                mag = mag / 10;
            end
        end
        else begin
            repeat ($urandom_range(1, maxd + 1))
                digs.push_back(8'(CH_ZERO + 8'($urandom_range(0, 9))));
        end
        first = 1;
        if (neg) begin
            push_char(CH_MINUS, 1'b0, k);
            first = 0;
        end
        foreach (digs[i]) begin
            push_char(digs[i], 1'b0, first ? k : 2'($urandom_range(0, 3)));
            first = 0;
        end
        // an excess digit already ends the number
        if (digs.size() <= maxd) begin
            if ($urandom_range(0, 2) == 0)
                push_char(8'($urandom_range(0, 255)), 1'b1, 2'($urandom_range(0, 3)));
            else
                push_char(any_non_digit(), 1'b0, 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_queue.size() > 0 &&
                         !(char_queue[0].drain && numbers_due.size() > 0)) begin
                    in_data  <= char_queue[0].item;
                    in_valid <= 1'b1;
                    void'(char_queue.pop_front());
                    if (!calm_phase() && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 8);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!long_hold_done && chars_taken >= 400) begin
                long_hold_done = 1;
                hold_left      = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (!calm_phase() && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 8) - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted chars, check accepted numbers
    always @(posedge clk)
    begin
        out_item_t want;
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("decimal_integer_field_parser test failed");
            $finish;
        end
        else begin
            in_taken = rst_n && in_valid && in_ready;
            if (in_taken) begin
                advance_parser(in_data);
                chars_taken++;
            end
            if (rst_n && out_valid && out_ready) begin
                if (numbers_due.size() == 0) begin
                    $error("unexpected number: value %0d ok %0b reason %0d",
                           out_data.value, out_data.ok, out_data.reason);
                    errors++;
                end
                else begin
                    want = numbers_due.pop_front();
                    numbers_checked++;
                    reason_seen[want.reason]++;
                    if (out_data.value !== want.value) begin
                        $error("value: expected %0d, got %0d", want.value, out_data.value);
                        errors++;
                    end
                    if (out_data.ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, out_data.ok);
                        errors++;
                    end
                    if (out_data.reason !== want.reason) begin
                        $error("reason: expected %0d, got %0d", want.reason, out_data.reason);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        bit mid_drain;
        mid_drain = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;

        // directed: i16 minimum, u32 one past max, u8 excess digit,
        // bare minus at buffer end, minus under u16
        push_text("-32768,", KIND_I16);
        push_text("4294967296", KIND_U32);
        push_char(8'hff, 1'b1, KIND_U32);
        push_text("1234", KIND_U8);
        push_char(CH_MINUS, 1'b0, KIND_I16);
        push_char(8'h00, 1'b1, KIND_I16);
        push_char(CH_MINUS, 1'b0, KIND_U16);

        drain_next = 1;
        while (items_queued < N_CHARS) begin
            if (!mid_drain && items_queued >= N_CHARS / 2) begin
                drain_next = 1;
                mid_drain  = 1;
            end
            if ($urandom_range(0, 4) == 0)
                push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          2'($urandom_range(0, 3)));
            else
                queue_number();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (char_queue.size() > 0 || in_valid || numbers_due.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d chars sent, %0d numbers checked", chars_taken, numbers_checked);
        $display("by reason: ok %0d, no digit %0d, too many digits %0d, out of range %0d",
                 reason_seen[REASON_OK], reason_seen[REASON_NO_DIGIT],
                 reason_seen[REASON_TOO_LONG], reason_seen[REASON_RANGE]);
        if (errors == 0 && numbers_due.size() == 0)
            $display("decimal_integer_field_parser test passed");
        else
            $display("decimal_integer_field_parser test failed");
        $finish;
    end
endmodule
